### src/ssprx_pkg.sv
// Shared types and constants for the servo status packet receiver.
package ssprx_pkg;

  // Width of the idle tick counter
  localparam int TICK_COUNT_BITS = 16;
  // Width of the timeout register
  localparam int TIMEOUT_BITS    = 16;
  // Width used to compare the tick counter with the timeout
  localparam int CMP_BITS = (TICK_COUNT_BITS > TIMEOUT_BITS) ? TICK_COUNT_BITS : TIMEOUT_BITS;

  typedef logic [TICK_COUNT_BITS-1:0] tick_t;
  typedef logic [TIMEOUT_BITS-1:0]    timeout_t;
  typedef logic [CMP_BITS-1:0]        cmp_t;
  typedef logic [8:0]                 index_t;

  // Operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Result kinds
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  // Packet framing
  localparam index_t LENGTH_INDEX    = 9'd3;
  localparam index_t SUM_FIRST_INDEX = 9'd2;
  localparam index_t HEADER_BYTES    = 9'd4;
  localparam index_t MAX_LENGTH      = 9'd259;

  localparam timeout_t TIMEOUT_RESET = 16'd20;

  // Item held in the input register
  typedef struct packed {
    logic       valid;
    logic [1:0] op;
    logic [7:0] rx_byte;
  } item_t;

  // Result payload
  typedef struct packed {
    logic       result_kind;
    index_t     byte_index;
    logic [7:0] byte_value;
    logic       packet_done;
    logic       checksum_bad;
  } result_t;

endpackage

### src/ssprx_if.sv
// Valid/ready channel interfaces for input items and results.
interface ssprx_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface ssprx_result_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [8:0] byte_index;
  logic [7:0] byte_value;
  logic       packet_done;
  logic       checksum_bad;

  modport source (output valid, output result_kind, output byte_index, output byte_value,
                  output packet_done, output checksum_bad, input ready);
  modport sink   (input valid, input result_kind, input byte_index, input byte_value,
                  input packet_done, input checksum_bad, output ready);
endinterface

### src/ssprx_in_stage.sv
// Input register: captures one item per transfer, released when the core takes it.
module ssprx_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  ssprx_item_if.sink           item,
  input  logic                 take,
  output ssprx_pkg::item_t     held
);

  logic       valid;
  logic [1:0] op;
  logic [7:0] rx_byte;
  logic       load_en;

  // Free slot, or the held item leaves this cycle
  assign load_en    = !valid || take;
  assign item.ready = load_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_en) begin
      valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en && item.valid) begin
      op      <= item.op;
      rx_byte <= item.rx_byte;
    end
  end

  assign held = '{valid: valid, op: op, rx_byte: rx_byte};

endmodule

### src/ssprx_core.sv
// Reception state, byte indexing, checksum and tick timeout.
module ssprx_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_wdata,
  input  ssprx_pkg::item_t      held,
  input  logic                  out_space,
  output logic                  take,
  output logic                  res_valid,
  output ssprx_pkg::result_t    res
);

  ssprx_pkg::timeout_t timeout_ticks;
  logic                receiving, receiving_next;
  ssprx_pkg::index_t   byte_count, byte_count_next;
  ssprx_pkg::index_t   packet_length, packet_length_next;
  logic [7:0]          running_sum, running_sum_next;
  ssprx_pkg::tick_t    idle_ticks, idle_ticks_next;

  ssprx_pkg::index_t   len_eff;
  logic                last;
  logic                bad;
  ssprx_pkg::tick_t    ticks_inc;
  logic                timed_out;

  // Timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= ssprx_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_wdata;
    end
  end

  // Byte framing: length taken from byte 3 on the fly
  always_comb begin
    len_eff = (byte_count == ssprx_pkg::LENGTH_INDEX)
            ? ({1'b0, held.rx_byte} + ssprx_pkg::HEADER_BYTES) : packet_length;
    last = (byte_count >= ssprx_pkg::LENGTH_INDEX) &&
           (({1'b0, byte_count} + 10'd1) >= {1'b0, len_eff});
    bad  = (held.rx_byte != ~running_sum);
  end

  // Saturating tick count and timeout compare
  always_comb begin
    ticks_inc = (idle_ticks == '1) ? idle_ticks : idle_ticks + 1'b1;
    timed_out = ssprx_pkg::cmp_t'(ticks_inc) >= ssprx_pkg::cmp_t'(timeout_ticks);
  end

  // Next state and result
  always_comb begin
    receiving_next     = receiving;
    byte_count_next    = byte_count;
    packet_length_next = packet_length;
    running_sum_next   = running_sum;
    idle_ticks_next    = idle_ticks;
    res_valid          = 1'b0;
    res                = '0;
    if (held.valid) begin
      priority if (held.op == ssprx_pkg::OP_START) begin
        receiving_next     = 1'b1;
        byte_count_next    = '0;
        packet_length_next = '0;
        running_sum_next   = '0;
        idle_ticks_next    = '0;
      end else if (receiving && held.op == ssprx_pkg::OP_BYTE) begin
        res_valid          = 1'b1;
        res.result_kind    = ssprx_pkg::KIND_BYTE;
        res.byte_index     = byte_count;
        res.byte_value     = held.rx_byte;
        res.packet_done    = last;
        res.checksum_bad   = last && bad;
        idle_ticks_next    = '0;
        packet_length_next = len_eff;
        if (last) begin
          receiving_next  = 1'b0;
          byte_count_next = '0;
        end else begin
          if (byte_count >= ssprx_pkg::SUM_FIRST_INDEX) begin
            running_sum_next = running_sum + held.rx_byte;
          end
          byte_count_next = byte_count + 1'b1;
        end
      end else if (receiving && held.op == ssprx_pkg::OP_TICK) begin
        idle_ticks_next = ticks_inc;
        if (timed_out) begin
          receiving_next  = 1'b0;
          byte_count_next = '0;
          idle_ticks_next = '0;
          res_valid       = 1'b1;
          res.result_kind = ssprx_pkg::KIND_TIMEOUT;
        end
      end else begin
        // idle byte or tick, or unused code: dropped
      end
    end
  end

  // Item leaves the input register unless its result has nowhere to go
  assign take = held.valid && (!res_valid || out_space);

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving     <= 1'b0;
      byte_count    <= '0;
      packet_length <= '0;
      running_sum   <= '0;
      idle_ticks    <= '0;
    end else if (take) begin
      receiving     <= receiving_next;
      byte_count    <= byte_count_next;
      packet_length <= packet_length_next;
      running_sum   <= running_sum_next;
      idle_ticks    <= idle_ticks_next;
    end
  end

`ifndef SYNTHESIS
  // Index is parked at zero whenever reception is off
  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    !receiving |-> byte_count == '0)
    else $error("byte index not cleared while idle");

  // Length never exceeds the largest framed packet
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    packet_length <= ssprx_pkg::MAX_LENGTH)
    else $error("packet length out of range");

  // Last byte ends reception
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    take && res_valid && res.packet_done |=> !receiving)
    else $error("still receiving after last byte");

  // Timeout result abandons the packet and clears the tick count
  a_timeout_idle: assert property (@(posedge clk) disable iff (rst)
    take && res_valid && res.result_kind == ssprx_pkg::KIND_TIMEOUT
      |=> !receiving && idle_ticks == '0)
    else $error("timeout did not abandon reception");
`endif

endmodule

### src/ssprx_out_reg.sv
// Result register driving the output channel.
module ssprx_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  ssprx_pkg::result_t   res,
  output logic                 out_space,
  ssprx_result_if.source       result
);

  logic               valid;
  ssprx_pkg::result_t data;

  assign out_space = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign result.valid        = valid;
  assign result.result_kind  = data.result_kind;
  assign result.byte_index   = data.byte_index;
  assign result.byte_value   = data.byte_value;
  assign result.packet_done  = data.packet_done;
  assign result.checksum_bad = data.checksum_bad;

endmodule

### src/servo_status_packet_receiver_unit.sv
// Top level of the servo status packet receiver.
//
//   channel  | dir | payload
//   item     | in  | op[1:0], rx_byte[7:0]
//   result   | out | result_kind, byte_index[8:0], byte_value[7:0], packet_done, checksum_bad
//   cfg      | in  | cfg_we, cfg_wdata[15:0] (timeout in ticks)
//
// One item per cycle unless a result stalls; a result is registered as its item is taken.
// Rate set by the single pass through the core between input and result registers.
// Synchronous reset clears both registers' valid flags and the state, and sets the timeout (20).
// A stalled result holds the input register only when that item yields a result.
module servo_status_packet_receiver_unit (
  input  logic             clk,
  input  logic             rst,
  ssprx_item_if.sink       item,
  ssprx_result_if.source   result,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata
);

  ssprx_pkg::item_t   held;
  ssprx_pkg::result_t res;
  logic               take;
  logic               res_valid;
  logic               out_space;
  logic               load;

  // Input register
  ssprx_in_stage u_in (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .take (take),
    .held (held)
  );

  // Reception logic
  ssprx_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .held      (held),
    .out_space (out_space),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  assign load = take && res_valid;

  // Result register
  ssprx_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .res       (res),
    .out_space (out_space),
    .result    (result)
  );

endmodule
